/* hdl/sprite_line_collision_check_assert.svh */
// ---------------------------------------------------------------------------
// Sprite line collision check - assertion macros
// Concurrent checks sampled on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef SPRITE_LINE_COLLISION_CHECK_ASSERT_SVH
`define SPRITE_LINE_COLLISION_CHECK_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SLCC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/slcc_pkg.sv */
// ---------------------------------------------------------------------------
// Sprite line collision check - shared package
// Sprite entry layout, configuration bundle and the pixel-test helpers.
// ---------------------------------------------------------------------------
package slcc_pkg;

	localparam int LINE_W    = 9;
	localparam int X_W       = 9;
	localparam int ATTR_W    = 8;
	localparam int PATTERN_W = 32;

	localparam logic [ATTR_W-1:0] ATTR_COLOUR_MASK = 8'h0F;
	localparam logic [ATTR_W-1:0] ATTR_MODE2_MASK  = 8'h60;
	localparam logic [8:0]        HIT_X_OFFSET     = 9'd12;
	localparam logic [9:0]        HIT_Y_OFFSET     = 10'd8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_TRANSPARENT = 2'd0,
		CFG_MODE_TWO    = 2'd1,
		CFG_LARGE       = 2'd2,
		CFG_MAGNIFIED   = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic transparent_collides;
		logic sprite_mode_two;
		logic large_sprites;
		logic magnified;
	} cfg_t;

	// One buffered sprite
	typedef struct packed {
		logic [ATTR_W-1:0]    attr;
		logic [X_W-1:0]       x;
		logic [PATTERN_W-1:0] pattern;
	} sprite_t;

	// Sprite joins the collision test
	function automatic logic takes_part(input cfg_t c, input logic [ATTR_W-1:0] attr);
		logic ok;
		ok = 1'b1;
		if (!c.transparent_collides && ((attr & ATTR_COLOUR_MASK) == '0))
			ok = 1'b0;
		if (c.sprite_mode_two && ((attr & ATTR_MODE2_MASK) != '0))
			ok = 1'b0;
		return ok;
	endfunction

	// Count of clear pixels left of the first set one (v nonzero)
	function automatic logic [4:0] lead_zeros(input logic [PATTERN_W-1:0] v);
		logic [4:0] n;
		n = '0;
		for (int k = 0; k < PATTERN_W; k++) begin
			if (v[k])
				n = 5'(PATTERN_W - 1 - k);
		end
		return n;
	endfunction

endpackage

/* hdl/slcc_front.sv */
// ---------------------------------------------------------------------------
// Sprite line collision check - front end
// Accepts sprite beats, writes them into the current buffer bank and hands
// a check job for the line to the back end on the beat marked last.
// ---------------------------------------------------------------------------
module slcc_front #(
	parameter int MAX_SPRITES = 8,
	localparam int IW = $clog2(MAX_SPRITES),
	localparam int CW = $clog2(MAX_SPRITES + 1),
	localparam int JW = 1 + CW + slcc_pkg::LINE_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,
	input  logic                 s_tlast,
	output logic                 wr_en,
	output logic [IW:0]          wr_addr,
	output slcc_pkg::sprite_t    wr_data,
	output logic                 job_valid,
	input  logic                 job_ready,
	output logic [JW-1:0]        job_data,
	input  logic                 done
);
	import slcc_pkg::*;

	localparam logic [1:0] PEND_MAX = 2'd2;

	logic          bank_q;
	logic [CW-1:0] count_q;
	logic [1:0]    pend_q;
	logic          accept;
	logic          room;
	logic [CW-1:0] count_next;

	// Two lines may be in flight, one per bank
	assign s_tready   = (pend_q != PEND_MAX) && job_ready;
	assign accept     = s_tvalid && s_tready;
	assign room       = count_q < CW'(MAX_SPRITES);
	assign count_next = room ? count_q + CW'(1) : count_q;

	// Buffer write, dropped once the bank is full
	assign wr_en           = accept && room;
	assign wr_addr         = {bank_q, count_q[IW-1:0]};
	assign wr_data.pattern = s_tdata[31:0];
	assign wr_data.x       = s_tdata[40:32];
	assign wr_data.attr    = s_tdata[48:41];

	// Job for the back end
	assign job_valid = accept && s_tlast;
	assign job_data  = {bank_q, count_next, s_tdata[57:49]};

	// Advance fill count, flip bank at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				bank_q  <= ~bank_q;
				count_q <= '0;
			end else begin
				count_q <= count_next;
			end
		end
	end

	// Track lines handed over but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({job_valid, done})
				2'b10:   pend_q <= pend_q + 2'd1;
				2'b01:   pend_q <= pend_q - 2'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

endmodule

/* hdl/slcc_job_fifo.sv */
// ---------------------------------------------------------------------------
// Sprite line collision check - job queue
// Two-entry queue of line check jobs between the front and back ends.
// ---------------------------------------------------------------------------
module slcc_job_fifo #(
	parameter int WIDTH = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Store job payload
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* hdl/slcc_back.sv */
// ---------------------------------------------------------------------------
// Sprite line collision check - back end
// Holds the two-bank sprite memory, walks every sprite pair of a line one
// pair per cycle through a three-stage compare pipe and registers the result.
// ---------------------------------------------------------------------------
module slcc_back #(
	parameter int MAX_SPRITES = 8,
	localparam int IW = $clog2(MAX_SPRITES),
	localparam int CW = $clog2(MAX_SPRITES + 1),
	localparam int JW = 1 + CW + slcc_pkg::LINE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  slcc_pkg::cfg_t    cfg,
	input  logic              wr_en,
	input  logic [IW:0]       wr_addr,
	input  slcc_pkg::sprite_t wr_data,
	input  logic              job_valid,
	output logic              job_ready,
	input  logic [JW-1:0]     job_data,
	output logic              done,
	output logic              m_tvalid,
	input  logic              m_tready,
	// m_tdata fields, low bit up: collided, hit_x[8:0], hit_y[9:0],
	// result_line[8:0], zero fill
	output logic [31:0]       m_tdata
);
	import slcc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	sprite_t              mem [2**(IW+1)];

	state_t               state_q;
	logic                 bank_q;
	logic [CW-1:0]        count_q;
	logic [LINE_W-1:0]    line_q;
	logic [IW-1:0]        i_q;
	logic [IW-1:0]        j_q;
	logic                 found_q;
	logic [8:0]           min_q;
	logic                 m_tvalid_q;
	logic [31:0]          m_tdata_q;

	logic                 job_bank;
	logic [CW-1:0]        job_count;
	logic [LINE_W-1:0]    job_line;
	logic                 issue;
	logic                 j_last;
	logic                 i_last;
	logic                 pipe_empty;
	logic                 out_free;

	sprite_t              spr_i_s1;
	sprite_t              spr_j_s1;
	logic                 v_s1;

	logic [31:0]          hit_s2;
	logic signed [9:0]    xi_s2;
	logic                 v_s2;

	logic signed [9:0]    xi;
	logic signed [9:0]    xj;
	logic signed [9:0]    x_gap;
	logic signed [9:0]    neg_x_gap;
	logic signed [9:0]    neg_xi;
	logic signed [9:0]    mag;
	logic                 in_range;
	logic [31:0]          shifted;
	logic [31:0]          vis_mask;
	logic [31:0]          hit;

	logic [4:0]           lz;
	logic signed [9:0]    xc;
	logic                 better;

	logic                 collided;
	logic [8:0]           hit_x;
	logic [9:0]           hit_y;

	assign job_bank  = job_data[JW-1];
	assign job_count = job_data[CW+LINE_W-1:LINE_W];
	assign job_line  = job_data[LINE_W-1:0];
	assign job_ready = (state_q == ST_IDLE);

	// Pair walk: i from 1 up, j below i
	assign issue      = (state_q == ST_RUN);
	assign j_last     = (({1'b0, j_q} + (IW+1)'(1)) == {1'b0, i_q});
	assign i_last     = ((CW'(i_q) + CW'(1)) == count_q);
	assign pipe_empty = !v_s1 && !v_s2;
	assign out_free   = !m_tvalid_q || m_tready;
	assign done       = (state_q == ST_DRAIN) && pipe_empty && out_free;

	// Sprite memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		spr_i_s1 <= mem[{bank_q, i_q}];
		spr_j_s1 <= mem[{bank_q, j_q}];
	end

	// Stage 1: align the earlier sprite to the later one and clip
	always_comb begin
		xi        = 10'(signed'(spr_i_s1.x));
		xj        = 10'(signed'(spr_j_s1.x));
		x_gap     = xj - xi;
		neg_x_gap = -x_gap;
		neg_xi    = -xi;
		mag       = cfg.large_sprites ? (cfg.magnified ? 10'sd32 : 10'sd16)
		                              : (cfg.magnified ? 10'sd16 : 10'sd8);
		in_range  = (x_gap > -mag) && (x_gap < mag);
		if (x_gap < 0)
			shifted = spr_j_s1.pattern << neg_x_gap[4:0];
		else
			shifted = spr_j_s1.pattern >> x_gap[4:0];
		if (xi <= -10'sd32)
			vis_mask = '0;
		else if (xi < 0)
			vis_mask = 32'hFFFF_FFFF >> neg_xi[4:0];
		else
			vis_mask = 32'hFFFF_FFFF;
		if (in_range && takes_part(cfg, spr_i_s1.attr) && takes_part(cfg, spr_j_s1.attr))
			hit = spr_i_s1.pattern & shifted & vis_mask;
		else
			hit = '0;
	end

	always_ff @(posedge clk) begin
		hit_s2 <= hit;
		xi_s2  <= xi;
	end

	// Pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// Stage 2: leftmost overlapping pixel of this pair
	assign lz     = lead_zeros(hit_s2);
	assign xc     = xi_s2 + signed'({5'b0, lz});
	assign better = v_s2 && (hit_s2 != '0) && (!found_q || (xc[8:0] < min_q));

	// Result fields
	assign collided = found_q && !min_q[8];
	assign hit_x    = collided ? min_q + HIT_X_OFFSET : '0;
	assign hit_y    = collided ? {1'b0, line_q} + HIT_Y_OFFSET : '0;

	// Sequencer, running minimum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bank_q     <= 1'b0;
			count_q    <= '0;
			line_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			found_q    <= 1'b0;
			min_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tready)
				m_tvalid_q <= 1'b0;
			if (better) begin
				found_q <= 1'b1;
				min_q   <= xc[8:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						bank_q  <= job_bank;
						count_q <= job_count;
						line_q  <= job_line;
						i_q     <= IW'(1);
						j_q     <= '0;
						found_q <= 1'b0;
						state_q <= (job_count >= CW'(2)) ? ST_RUN : ST_DRAIN;
					end
				end
				ST_RUN: begin
					if (!j_last) begin
						j_q <= j_q + IW'(1);
					end else if (!i_last) begin
						i_q <= i_q + IW'(1);
						j_q <= '0;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty && out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b0, line_q, hit_y, hit_x, collided};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* hdl/sprite_line_collision_check.sv */
// Sprite beats are taken one per cycle while the front is not stalled on two
// pending lines or a full job queue; two lines may be buffered at once. The
// back end tests one sprite pair per cycle on its shared compare pipe; a line
// with fewer than two sprites skips the pair walk and goes straight to drain.
// Reset clears the configuration, fill counts, queue and result register;
// the sprite memory is left as is and only entries of the current line are read.
// ---------------------------------------------------------------------------
// Sprite line collision check - top level
// Buffers the sprites of a scanline and reports the leftmost pixel where two
// visible sprites overlap.
// ---------------------------------------------------------------------------
module sprite_line_collision_check #(
	parameter int MAX_SPRITES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata fields, low bit up: pattern_row[31:0], x_position[8:0],
	// colour_attribute[7:0], line_number[8:0], zero fill
	input  logic [63:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata fields, low bit up: collided, hit_x[8:0], hit_y[9:0],
	// result_line[8:0], zero fill
	output logic [31:0] m_tdata
);
	import slcc_pkg::*;

	localparam int IW = $clog2(MAX_SPRITES);
	localparam int CW = $clog2(MAX_SPRITES + 1);
	localparam int JW = 1 + CW + LINE_W;

	cfg_t          cfg_q;
	logic          wr_en;
	logic [IW:0]   wr_addr;
	sprite_t       wr_data;
	logic          job_push_valid;
	logic          job_push_ready;
	logic [JW-1:0] job_push_data;
	logic          job_pop_valid;
	logic          job_pop_ready;
	logic [JW-1:0] job_pop_data;
	logic          done;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRANSPARENT: cfg_q.transparent_collides <= cfg_data;
				CFG_MODE_TWO:    cfg_q.sprite_mode_two      <= cfg_data;
				CFG_LARGE:       cfg_q.large_sprites        <= cfg_data;
				CFG_MAGNIFIED:   cfg_q.magnified            <= cfg_data;
				default:         cfg_q                      <= cfg_q;
			endcase
		end
	end

	slcc_front #(.MAX_SPRITES(MAX_SPRITES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_push_valid),
		.job_ready (job_push_ready),
		.job_data  (job_push_data),
		.done      (done)
	);

	slcc_job_fifo #(.WIDTH(JW)) u_job_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_push_valid),
		.push_ready (job_push_ready),
		.push_data  (job_push_data),
		.pop_valid  (job_pop_valid),
		.pop_ready  (job_pop_ready),
		.pop_data   (job_pop_data)
	);

	slcc_back #(.MAX_SPRITES(MAX_SPRITES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_pop_valid),
		.job_ready (job_pop_ready),
		.job_data  (job_pop_data),
		.done      (done),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`include "sprite_line_collision_check_assert.svh"

	// A line job never meets a full queue
	`SLCC_ASSERT_SAME(a_job_fits, job_push_valid, job_push_ready, "job queue overflow")
	// Front stops taking sprites while the queue is full
	`SLCC_ASSERT_SAME(a_stall_on_full, s_tready, job_push_ready, "beat taken with full queue")
	// A finished check shows up on the output in the next cycle
	`SLCC_ASSERT_NEXT(a_done_shows, done, m_tvalid, "finished line not presented")

endmodule

/* test/tb_sprite_line_collision_check.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sprite line collision check - testbench
// Streams scanlines of sprites into the block and keeps its own model of the
// sprite buffer and pair test. Each result beat is compared field by field
// with the oldest pending line, under random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module tb_sprite_line_collision_check;
	import slcc_pkg::*;

	localparam int MAX_SPRITES   = 8;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 48;
	localparam int DRAIN_LIMIT   = 20000;

	// Matches m_tdata[28:0], highest field first
	typedef struct packed {
		logic [8:0] result_line;
		logic [9:0] hit_y;
		logic [8:0] hit_x;
		logic       collided;
	} line_hit_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	cfg_index_t  cfg_index = CFG_TRANSPARENT;
	logic        cfg_data  = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;

	// Model of the block
	logic [31:0] row_buf  [MAX_SPRITES];
	int          x_buf    [MAX_SPRITES];
	logic [7:0]  attr_buf [MAX_SPRITES];
	int          buffered = 0;
	cfg_t        model_cfg = '0;
	line_hit_t   pending_hits[$];

	int   error_count  = 0;
	int   sprites_sent = 0;
	logic source_gaps  = 1'b1;
	logic sink_gaps    = 1'b1;
	logic hold_request = 1'b0;
	logic sink_hold    = 1'b0;

	sprite_line_collision_check #(
		.MAX_SPRITES(MAX_SPRITES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #10 clk = ~clk;

	task automatic report_failure(input string msg);
		$display("%0t ERROR: %s", $time, msg);
		error_count++;
	endtask

	function automatic logic joins_collision(input logic [7:0] attr);
		if (!model_cfg.transparent_collides && (attr & ATTR_COLOUR_MASK) == '0)
			return 1'b0;
		if (model_cfg.sprite_mode_two && (attr & ATTR_MODE2_MASK) != '0)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic int first_set_pixel(input logic [31:0] v);
		for (int k = 31; k >= 0; k--) begin
			if (v[k])
				return 31 - k;
		end
		return 32;
	endfunction

	// Test every buffered pair, later sprite against each earlier one
	function automatic line_hit_t predict_line_hit(input logic [8:0] line);
		int        span;
		int        leftmost;
		int        x_gap;
		logic [31:0] row_j;
		logic [31:0] overlap;
		line_hit_t r;
		span = (model_cfg.large_sprites ? 16 : 8) * (model_cfg.magnified ? 2 : 1);
		leftmost = 999;
		for (int i = buffered - 1; i >= 1; i--) begin
			if (joins_collision(attr_buf[i])) begin
				for (int j = i - 1; j >= 0; j--) begin
					x_gap = x_buf[j] - x_buf[i];
					if (joins_collision(attr_buf[j]) && x_gap > -span && x_gap < span) begin
						row_j = (x_gap < 0) ? (row_buf[j] << (-x_gap)) : (row_buf[j] >> x_gap);
						overlap = row_buf[i] & row_j;
						// hide pixels left of the screen
						if (x_buf[i] <= -32)
							overlap = '0;
						else if (x_buf[i] < 0)
							overlap &= 32'hFFFF_FFFF >> (-x_buf[i]);
						if (overlap != '0 && x_buf[i] + first_set_pixel(overlap) < leftmost)
							leftmost = x_buf[i] + first_set_pixel(overlap);
					end
				end
			end
		end
		r.result_line = line;
		if (leftmost < 256) begin
			r.collided = 1'b1;
			r.hit_x    = 9'(leftmost + 12);
			r.hit_y    = {1'b0, line} + 10'd8;
		end else begin
			r.collided = 1'b0;
			r.hit_x    = '0;
			r.hit_y    = '0;
		end
		return r;
	endfunction

	// Offer one sprite beat, wait for the handshake, then update the model
	task automatic send_sprite(input logic [31:0] pattern, input int x,
			input logic [7:0] attr, input logic [8:0] line, input logic last);
		while (source_gaps && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, line, attr, 9'(x), pattern};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sprites_sent++;
		if (buffered < MAX_SPRITES) begin
			row_buf[buffered]  = pattern;
			x_buf[buffered]    = x;
			attr_buf[buffered] = attr;
			buffered++;
		end
		if (last) begin
			pending_hits = {pending_hits, predict_line_hit(line)};
			buffered = 0;
		end
	endtask

	// Drop valid and let every pending line come back
	task automatic wait_idle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_TRANSPARENT: model_cfg.transparent_collides = value;
			CFG_MODE_TWO:    model_cfg.sprite_mode_two      = value;
			CFG_LARGE:       model_cfg.large_sprites        = value;
			CFG_MAGNIFIED:   model_cfg.magnified            = value;
			default:         ;
		endcase
	endtask

	// Write all registers once the block has gone quiet
	task automatic write_settings(input cfg_t c);
		wait_idle();
		write_register(CFG_TRANSPARENT, c.transparent_collides);
		write_register(CFG_MODE_TWO, c.sprite_mode_two);
		write_register(CFG_LARGE, c.large_sprites);
		write_register(CFG_MAGNIFIED, c.magnified);
		cfg_we <= 1'b0;
	endtask

	// One scanline of clustered sprites, with some overfull lines and noise
	task automatic send_random_line();
		int          n;
		int          roll;
		int          span;
		int          base;
		int          x;
		logic [8:0]  line;
		logic [8:0]  beat_line;
		logic [31:0] pattern;
		logic [7:0]  attr;
		roll = $urandom_range(99);
		if (roll < 8)
			n = $urandom_range(9, 12);
		else if (roll < 14)
			n = 1;
		else
			n = $urandom_range(2, 8);
		span = (model_cfg.large_sprites ? 16 : 8) * (model_cfg.magnified ? 2 : 1);
		base = int'($urandom_range(0, 287)) - 32;
		line = 9'($urandom_range(0, 511));
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 5)
				x = int'($urandom_range(0, 287)) - 32;
			else
				x = base + int'($urandom_range(0, 2 * span)) - span;
			if (x < -32)
				x = -32;
			if (x > 255)
				x = 255;
			roll = $urandom_range(99);
			if (roll < 40)
				pattern = $urandom;
			else if (roll < 80)
				pattern = $urandom & ~(32'hFFFF_FFFF >> span);
			else if (roll < 90)
				pattern = 32'hFFFF_FFFF;
			else
				pattern = 32'h8000_0000 >> $urandom_range(0, 31);
			attr = 8'($urandom_range(0, 255));
			if ($urandom_range(99) < 60)
				attr &= ~ATTR_MODE2_MASK;
			if ($urandom_range(99) < 10)
				attr &= ~ATTR_COLOUR_MASK;
			// stray line numbers on beats that do not close the line
			beat_line = ($urandom_range(99) < 3) ? 9'($urandom_range(0, 511)) : line;
			send_sprite(pattern, x, attr, (k == n - 1) ? line : beat_line, k == n - 1);
		end
	endtask

	task automatic test_directed();
		write_settings(cfg_t'(4'b0000));
		// lone sprite: nothing to pair with
		send_sprite(32'hFFFF_FFFF, 0, 8'h0F, 9'd0, 1'b1);
		// full overlap at the left edge
		send_sprite(32'hFFFF_FFFF, 0, 8'h01, 9'd1, 1'b0);
		send_sprite(32'hFFFF_FFFF, 0, 8'h0F, 9'd1, 1'b1);
		// overlap on the last visible pixel, top line number
		send_sprite(32'h8000_0000, 255, 8'h01, 9'd511, 1'b0);
		send_sprite(32'h8000_0000, 255, 8'h02, 9'd511, 1'b1);
		// overlap right of the screen edge is not reported
		send_sprite(32'h0040_0000, 250, 8'h01, 9'd300, 1'b0);
		send_sprite(32'h0040_0000, 250, 8'h01, 9'd300, 1'b1);
		// sprite fully off the left edge is hidden, one pixel in shows
		send_sprite(32'hFFFF_FFFF, -31, 8'h01, 9'd7, 1'b0);
		send_sprite(32'hFFFF_FFFF, -32, 8'h01, 9'd7, 1'b0);
		send_sprite(32'hFFFF_FFFF, -31, 8'h01, 9'd7, 1'b1);
		// colour 0 sprites stay out while transparent collision is off
		send_sprite(32'hFFFF_FFFF, 100, 8'h00, 9'd42, 1'b0);
		send_sprite(32'hFFFF_FFFF, 100, 8'hF0, 9'd42, 1'b1);
		// full buffer: the overlapping ninth sprite is dropped, its mark still closes
		for (int k = 0; k < MAX_SPRITES; k++)
			send_sprite((k == 1) ? 32'h0 : 32'hFF00_0000, k * 30, 8'hFF, 9'd256, 1'b0);
		send_sprite(32'hFF00_0000, 0, 8'h01, 9'd256, 1'b1);
	endtask

	task automatic test_attribute_modes();
		// transparent collision on
		write_settings(cfg_t'(4'b1000));
		send_sprite(32'hFFFF_FFFF, 40, 8'h00, 9'd10, 1'b0);
		send_sprite(32'hFFFF_FFFF, 40, 8'h80, 9'd10, 1'b1);
		// mode 2 drops CC and IC sprites, EC alone still counts
		write_settings(cfg_t'(4'b0100));
		send_sprite(32'hFFFF_FFFF, 10, 8'h01, 9'd11, 1'b0);
		send_sprite(32'hFFFF_FFFF, 10, 8'h41, 9'd11, 1'b0);
		send_sprite(32'hFFFF_FFFF, 10, 8'h21, 9'd11, 1'b0);
		send_sprite(32'hFFFF_FFFF, 14, 8'h81, 9'd11, 1'b1);
		// large magnified sprites reach 31 pixels apart
		write_settings(cfg_t'(4'b0011));
		send_sprite(32'hFFFF_FFFF, 0, 8'h01, 9'd12, 1'b0);
		send_sprite(32'hFFFF_FFFF, 20, 8'h01, 9'd12, 1'b1);
	endtask

	task automatic test_random_settings();
		int start;
		for (int s = 0; s < 16; s++) begin
			write_settings(cfg_t'(4'(s)));
			start = sprites_sent;
			while (sprites_sent - start < 64)
				send_random_line();
		end
	endtask

	task automatic test_back_to_back();
		int start;
		write_settings(cfg_t'(4'b1111));
		source_gaps = 1'b0;
		sink_gaps   = 1'b0;
		start = sprites_sent;
		while (sprites_sent - start < 150)
			send_random_line();
		source_gaps = 1'b1;
		sink_gaps   = 1'b1;
	endtask

	// Keep offering lines while the receiver holds off
	task automatic test_receiver_hold();
		int start;
		write_settings(cfg_t'(4'b0101));
		hold_request = 1'b1;
		start = sprites_sent;
		while (sprites_sent - start < 200)
			send_random_line();
	endtask

	// Receiver hold-off, counted here
	initial begin
		wait (hold_request);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// Check each result beat and drive ready
	always @(posedge clk) begin
		line_hit_t got;
		line_hit_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = line_hit_t'(m_tdata[28:0]);
			if (pending_hits.size() == 0) begin
				report_failure($sformatf("result beat for line %0d with no line pending",
					got.result_line));
			end else begin
				want = pending_hits.pop_front();
				if (got.collided !== want.collided)
					report_failure($sformatf("line %0d collided: got %0b expected %0b",
						want.result_line, got.collided, want.collided));
				if (got.hit_x !== want.hit_x)
					report_failure($sformatf("line %0d hit_x: got %0d expected %0d",
						want.result_line, got.hit_x, want.hit_x));
				if (got.hit_y !== want.hit_y)
					report_failure($sformatf("line %0d hit_y: got %0d expected %0d",
						want.result_line, got.hit_y, want.hit_y));
				if (got.result_line !== want.result_line)
					report_failure($sformatf("result_line: got %0d expected %0d",
						got.result_line, want.result_line));
			end
		end
		m_tready <= !sink_hold && (!sink_gaps || $urandom_range(99) >= 33);
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_attribute_modes();
		test_random_settings();
		test_back_to_back();
		test_receiver_hold();
		wait_idle();
		if (pending_hits.size() != 0)
			report_failure($sformatf("%0d lines never answered", pending_hits.size()));
		if (error_count == 0)
			$display("sprite_line_collision_check test passed");
		else
			$display("sprite_line_collision_check test failed");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("sprite_line_collision_check test failed");
		$finish;
	end

endmodule
